// File: src/satq_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the summed-area table engine.
// Used by every module of the block but satq_ram; depends on nothing.
package satq_pkg;

  localparam int MAX_DIM = 256;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int DIM_W   = 9;
  localparam int WORD_W  = 32;
  localparam int CMD_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int TDATA_W = 72;
  localparam int OUT_TDATA_W = 32;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BUILD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 2'd1;

  typedef logic [DIM_W-1:0]  dim_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    dim_t              col_end;
    dim_t              row_end;
    dim_t              col;
    dim_t              row;
  } item_t;

  typedef struct packed {
    dim_t rows_in_use;
    dim_t cols_in_use;
  } cfg_t;

  typedef struct packed {
    logic  valid;
    word_t rect_sum;
  } result_t;

  function automatic addr_t slot(input dim_t r, input dim_t c);
    dim_t rm;
    dim_t cm;
    rm = r - dim_t'(1);
    cm = c - dim_t'(1);
    return {rm[IDX_W-1:0], cm[IDX_W-1:0]};
  endfunction

  function automatic dim_t sat_dim(input dim_t v);
    return (v > dim_t'(MAX_DIM)) ? dim_t'(MAX_DIM) : v;
  endfunction

  function automatic logic in_dim(input dim_t v);
    return (v != '0) && (v <= dim_t'(MAX_DIM));
  endfunction

endpackage

// File: src/satq_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module satq_ram #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [1 << ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: src/satq_engine.sv
`timescale 1ns / 1ps
// Command sequencer of the summed-area table: element store, prefix store,
// build walk and four-read rectangle query. Depends on satq_pkg and satq_ram.
module satq_engine (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [satq_pkg::CMD_W-1:0] in_cmd,
  input  satq_pkg::item_t         in_item,
  input  satq_pkg::cfg_t          cfg,
  input  logic                    out_free,
  output satq_pkg::result_t       res
);
  import satq_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_B_RD  = 5'b00010,
    ST_B_WR  = 5'b00100,
    ST_Q_RD  = 5'b01000,
    ST_Q_FIN = 5'b10000
  } state_t;

  state_t state, state_next;

  dim_t  built_rows, built_cols;
  dim_t  brow, bcol;
  word_t row_acc;
  logic  top_use;

  dim_t  q_r1, q_c1, q_r2, q_c2;
  logic [1:0] qidx;
  word_t acc, acc_next;
  logic  pend, pend_sign, pend_use;

  logic  src_we;
  addr_t src_raddr;
  word_t src_rdata;
  logic  pre_we;
  addr_t pre_waddr, pre_raddr;
  word_t pre_wdata, pre_rdata;

  logic  accept;
  dim_t  term_r, term_c;
  logic  term_sign, term_use;
  word_t build_sum;
  dim_t  new_rows, new_cols;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  assign src_we    = accept && (in_cmd == CMD_LOAD) && in_dim(in_item.row) &&
                     in_dim(in_item.col);
  assign src_raddr = slot(brow, bcol);

  assign build_sum = src_rdata + (top_use ? pre_rdata : '0) + row_acc;
  assign pre_we    = (state == ST_B_WR);
  assign pre_waddr = slot(brow, bcol);
  assign pre_wdata = build_sum;

  assign new_rows = sat_dim(cfg.rows_in_use);
  assign new_cols = sat_dim(cfg.cols_in_use);

  always_comb begin
    term_r    = q_r2;
    term_c    = q_c2;
    term_sign = 1'b0;
    term_use  = 1'b1;
    case (qidx)
      2'd0: begin
        term_r = q_r2;
        term_c = q_c2;
      end
      2'd1: begin
        term_r    = q_r1 - dim_t'(1);
        term_sign = 1'b1;
        term_use  = (q_r1 > dim_t'(1));
      end
      2'd2: begin
        term_c    = q_c1 - dim_t'(1);
        term_sign = 1'b1;
        term_use  = (q_c1 > dim_t'(1));
      end
      2'd3: begin
        term_r   = q_r1 - dim_t'(1);
        term_c   = q_c1 - dim_t'(1);
        term_use = (q_r1 > dim_t'(1)) && (q_c1 > dim_t'(1));
      end
      default: begin
        term_use = 1'b0;
      end
    endcase
    term_use = term_use && (term_r != '0) && (term_c != '0) &&
               (term_r <= built_rows) && (term_c <= built_cols);
  end

  always_comb begin
    if (state == ST_B_RD) begin
      pre_raddr = slot(brow - dim_t'(1), bcol);
    end else begin
      pre_raddr = slot(term_r, term_c);
    end
  end

  always_comb begin
    acc_next = acc;
    if (pend && pend_use) begin
      acc_next = pend_sign ? (acc - pre_rdata) : (acc + pre_rdata);
    end
  end

  assign res.valid    = (state == ST_Q_FIN) && out_free;
  assign res.rect_sum = acc_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (in_cmd == CMD_BUILD) && (new_rows != '0) &&
            (new_cols != '0)) begin
          state_next = ST_B_RD;
        end else if (accept && (in_cmd == CMD_QUERY)) begin
          state_next = ST_Q_RD;
        end
      end
      ST_B_RD: begin
        state_next = ST_B_WR;
      end
      ST_B_WR: begin
        if ((bcol == built_cols) && (brow == built_rows)) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_B_RD;
        end
      end
      ST_Q_RD: begin
        if (qidx == 2'd3) begin
          state_next = ST_Q_FIN;
        end
      end
      ST_Q_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      built_rows <= '0;
      built_cols <= '0;
      pend       <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= (state == ST_Q_RD);
      if (accept && (in_cmd == CMD_BUILD)) begin
        built_rows <= new_rows;
        built_cols <= new_cols;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      brow    <= dim_t'(1);
      bcol    <= dim_t'(1);
      row_acc <= '0;
      qidx    <= '0;
      acc     <= '0;
      q_r1    <= in_item.row;
      q_c1    <= in_item.col;
      q_r2    <= in_item.row_end;
      q_c2    <= in_item.col_end;
    end
    if (state == ST_B_RD) begin
      top_use <= (brow > dim_t'(1));
    end
    if (state == ST_B_WR) begin
      if (bcol == built_cols) begin
        bcol    <= dim_t'(1);
        brow    <= brow + dim_t'(1);
        row_acc <= '0;
      end else begin
        bcol    <= bcol + dim_t'(1);
        row_acc <= row_acc + src_rdata;
      end
    end
    if (state == ST_Q_RD) begin
      qidx <= qidx + 2'd1;
    end
    if ((state == ST_Q_RD) || (state == ST_Q_FIN)) begin
      acc <= acc_next;
    end
    pend_sign <= term_sign;
    pend_use  <= term_use;
  end

  satq_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (WORD_W)
  ) u_source_ram (
    .clk   (clk),
    .we    (src_we),
    .waddr (slot(in_item.row, in_item.col)),
    .wdata (in_item.value),
    .raddr (src_raddr),
    .rdata (src_rdata)
  );

  satq_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (WORD_W)
  ) u_prefix_ram (
    .clk   (clk),
    .we    (pre_we),
    .waddr (pre_waddr),
    .wdata (pre_wdata),
    .raddr (pre_raddr),
    .rdata (pre_rdata)
  );

endmodule

// File: src/summed_area_table_query.sv
`timescale 1ns / 1ps
// Top level of the summed-area table engine: stream ports, configuration
// registers and the output word register. Depends on satq_pkg and satq_engine.
//
//   Channel   Direction  Handshake          Contents
//   s_*       in         s_tvalid/s_tready  command word (kind in s_tuser)
//   m_*       out        m_tvalid/m_tready  rectangle sum word
//   cfg_*     in         cfg_valid/cfg_ready register index and value
//
// A load leaves the block idle with its input ready. A query makes four reads
// from the single read port of the prefix memory, then folds in the last
// read while it waits for a free output. A build reads then writes each of
// rows_in_use x cols_in_use entries, capped at MAX_DIM, in the prefix memory.
// Reset clears the built extent and the output valid flag; the memories keep
// their contents. A stalled output holds a finished query until it is taken.
module summed_area_table_query (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // row[8:0], col[17:9], row_end[26:18], col_end[35:27], value[67:36], zeros
  input  logic [satq_pkg::TDATA_W-1:0]      s_tdata,
  // command[1:0]
  input  logic [satq_pkg::CMD_W-1:0]        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // rect_sum[31:0]
  output logic [satq_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [satq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [satq_pkg::DIM_W-1:0]        cfg_data
);
  import satq_pkg::*;

  cfg_t    cfg;
  item_t   item;
  result_t res;
  logic    out_free;
  word_t   out_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rows_in_use <= dim_t'(MAX_DIM);
      cfg.cols_in_use <= dim_t'(MAX_DIM);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_ROWS_IN_USE) begin
        cfg.rows_in_use <= cfg_data;
      end else if (cfg_index == REG_COLS_IN_USE) begin
        cfg.cols_in_use <= cfg_data;
      end
    end
  end

  assign item = item_t'(s_tdata[$bits(item_t)-1:0]);

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_data <= res.rect_sum;
    end
  end

  assign m_tdata = out_data;

  satq_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_cmd   (s_tuser),
    .in_item  (item),
    .cfg      (cfg),
    .out_free (out_free),
    .res      (res)
  );

endmodule

// File: src/satq_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the summed-area table engine and its bind to the top.
// Depends on satq_pkg.
module satq_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic [satq_pkg::CMD_W-1:0]        s_tuser,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [satq_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import satq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == CMD_QUERY) |=> !s_tready)
    else $error("input taken right after a query");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == CMD_LOAD) |=> s_tready)
    else $error("load left the block busy");

  a_out_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result word appeared without a query in progress");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind summed_area_table_query satq_checker u_satq_checker (.*);

// File: test/tb_summed_area_table_query.sv
`timescale 1ns / 1ps
// Self-checking bench for the summed-area table engine. It drives directed and random
// command words, predicts every rectangle sum and stalls both streams at random.
// Depends on satq_pkg and summed_area_table_query.
module tb_summed_area_table_query;
  import satq_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int CELLS = MAX_DIM * MAX_DIM;
  localparam int DIM_CODE_MAX = (1 << DIM_W) - 1;

  class area_sum_tracker;
    word_t elements[CELLS];
    word_t prefix[CELLS];
    int unsigned built_rows;
    int unsigned built_cols;
    int unsigned rows_in_use = MAX_DIM;
    int unsigned cols_in_use = MAX_DIM;
    word_t pending_sums[$];
    int errors;

    function int unsigned cell_index(int unsigned r, int unsigned c);
      return (r - 1) * MAX_DIM + (c - 1);
    endfunction

    function word_t corner_sum(int unsigned r, int unsigned c);
      if (r == 0 || c == 0 || r > built_rows || c > built_cols) return '0;
      return prefix[cell_index(r, c)];
    endfunction

    function void build_table();
      built_rows = (rows_in_use > MAX_DIM) ? MAX_DIM : rows_in_use;
      built_cols = (cols_in_use > MAX_DIM) ? MAX_DIM : cols_in_use;
      for (int unsigned r = 1; r <= built_rows; r++) begin
        for (int unsigned c = 1; c <= built_cols; c++) begin
          prefix[cell_index(r, c)] = elements[cell_index(r, c)] + corner_sum(r - 1, c)
                                   + corner_sum(r, c - 1) - corner_sum(r - 1, c - 1);
        end
      end
    endfunction

    function word_t box_sum(int unsigned r1, int unsigned c1, int unsigned r2,
                            int unsigned c2);
      word_t sum;
      sum = corner_sum(r2, c2);
      if (r1 > 1) sum -= corner_sum(r1 - 1, c2);
      if (c1 > 1) sum -= corner_sum(r2, c1 - 1);
      if (r1 > 1 && c1 > 1) sum += corner_sum(r1 - 1, c1 - 1);
      return sum;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] index, dim_t data);
      if (index == REG_ROWS_IN_USE) rows_in_use = data;
      else if (index == REG_COLS_IN_USE) cols_in_use = data;
    endfunction

    function void note_word(logic [CMD_W-1:0] cmd, dim_t row, dim_t col, dim_t row_end,
                            dim_t col_end, word_t value);
      case (cmd)
        CMD_LOAD: begin
          if (row != 0 && col != 0 && row <= MAX_DIM && col <= MAX_DIM)
            elements[cell_index(row, col)] = value;
        end
        CMD_BUILD: begin
          build_table();
        end
        CMD_QUERY: begin
          pending_sums.push_back(box_sum(row, col, row_end, col_end));
        end
        default: begin
        end
      endcase
    endfunction

    function void check_sum(word_t actual);
      word_t expected;
      if (pending_sums.size() == 0) begin
        $error("rect_sum: unexpected word, expected none, actual %0d", $signed(actual));
        errors++;
        return;
      end
      expected = pending_sums.pop_front();
      if (actual !== expected) begin
        $error("rect_sum mismatch: expected %0d, actual %0d", $signed(expected),
               $signed(actual));
        errors++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [TDATA_W-1:0]     s_tdata = '0;
  logic [CMD_W-1:0]       s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  dim_t                   cfg_data = '0;

  int send_idle = 23;
  int recv_idle = 48;
  int hold_left = 0;
  bit cell_loaded[CELLS];
  area_sum_tracker sums = new();

  summed_area_table_query u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sums.check_sum(m_tdata);
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_word(input logic [CMD_W-1:0] cmd, input int row, col, row_end, col_end,
                           input word_t value);
    item_t item;
    item.row = dim_t'(row);
    item.col = dim_t'(col);
    item.row_end = dim_t'(row_end);
    item.col_end = dim_t'(col_end);
    item.value = value;
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= TDATA_W'(item);
    s_tuser <= cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sums.note_word(cmd, item.row, item.col, item.row_end, item.col_end, value);
    if (cmd == CMD_LOAD && row >= 1 && col >= 1 && row <= MAX_DIM && col <= MAX_DIM)
      cell_loaded[(row - 1) * MAX_DIM + col - 1] = 1'b1;
  endtask

  task automatic set_extent(input int rows, input int cols);
    logic [CFG_IDX_W-1:0] index;
    dim_t data;
    for (int i = 0; i < 2; i++) begin
      index = (i == 0) ? REG_ROWS_IN_USE : REG_COLS_IN_USE;
      data = dim_t'((i == 0) ? rows : cols);
      cfg_valid <= 1'b1;
      cfg_index <= index;
      cfg_data <= data;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sums.set_reg(index, data);
    end
    cfg_valid <= 1'b0;
  endtask

  // A build leaves no word behind, so wait out a build of the last extent after the last sum.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sums.pending_sums.size() != 0) @(posedge clk);
    repeat (2 * sums.built_rows * sums.built_cols + 16) @(posedge clk);
  endtask

  initial begin
    int rows, cols, rs, cs, rb, cb, r1, r2, c1, c2, pick;
    word_t extreme_vals[9];
    extreme_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'h5,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0001};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_extent(3, 3);
    send_word(CMD_QUERY, 1, 1, MAX_DIM, MAX_DIM, '0);
    for (int r = 1; r <= 3; r++) begin
      for (int c = 1; c <= 3; c++) begin
        send_word(CMD_LOAD, r, c, 0, 0, extreme_vals[(r - 1) * 3 + c - 1]);
      end
    end
    send_word(CMD_LOAD, 0, 1, 0, 0, 32'h1234_5678);
    send_word(CMD_LOAD, 1, 0, 0, 0, 32'h1234_5678);
    send_word(CMD_LOAD, MAX_DIM + 1, 1, 0, 0, 32'h1234_5678);
    send_word(CMD_LOAD, DIM_CODE_MAX, DIM_CODE_MAX, 0, 0, 32'h1234_5678);
    send_word(CMD_UNUSED, DIM_CODE_MAX, DIM_CODE_MAX, DIM_CODE_MAX, DIM_CODE_MAX, '1);
    send_word(CMD_BUILD, 0, 0, 0, 0, '0);
    send_word(CMD_QUERY, 1, 1, 3, 3, '0);
    send_word(CMD_QUERY, 2, 2, 2, 2, '0);
    send_word(CMD_QUERY, 3, 3, 1, 1, '0);
    send_word(CMD_QUERY, 0, 0, 3, 3, '0);
    send_word(CMD_QUERY, 2, 2, MAX_DIM, MAX_DIM, '0);
    send_word(CMD_QUERY, DIM_CODE_MAX, DIM_CODE_MAX, DIM_CODE_MAX, DIM_CODE_MAX, '0);
    send_word(CMD_QUERY, 1, 2, 3, 2, '0);

    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        1: begin rows = MAX_DIM; cols = 1; end
        2: begin rows = 0; cols = 5; end
        5: begin rows = 1; cols = MAX_DIM; end
        6: begin rows = 300; cols = 1; end
        9: begin rows = 1; cols = 300; end
        10: begin rows = 7; cols = 0; end
        default: begin
          rows = $urandom_range(1, 12);
          cols = $urandom_range(1, 12);
        end
      endcase
      drain();
      send_idle = (phase < 4) ? 23 : (phase < 8) ? 48 : 0;
      recv_idle = (phase < 4) ? 48 : (phase < 8) ? 23 : 0;
      set_extent(rows, cols);
      rs = (rows > MAX_DIM) ? MAX_DIM : rows;
      cs = (cols > MAX_DIM) ? MAX_DIM : cols;
      for (int r = 1; r <= rs; r++) begin
        for (int c = 1; c <= cs; c++) begin
          if (!cell_loaded[(r - 1) * MAX_DIM + c - 1])
            send_word(CMD_LOAD, r, c, $urandom_range(0, DIM_CODE_MAX),
                      $urandom_range(0, DIM_CODE_MAX), $urandom);
        end
      end
      if (phase == 8) hold_left = 300;
      for (int n = 0; n < 32; n++) begin
        pick = $urandom_range(99);
        rb = sums.built_rows;
        cb = sums.built_cols;
        if (pick < 35) begin
          r1 = (rs > 0) ? $urandom_range(1, rs) : $urandom_range(1, MAX_DIM);
          c1 = (cs > 0) ? $urandom_range(1, cs) : $urandom_range(1, MAX_DIM);
          send_word(CMD_LOAD, r1, c1, $urandom_range(0, DIM_CODE_MAX),
                    $urandom_range(0, DIM_CODE_MAX), $urandom);
        end else if (pick < 45) begin
          send_word(CMD_BUILD, $urandom_range(0, DIM_CODE_MAX), $urandom_range(0, DIM_CODE_MAX),
                    $urandom_range(0, DIM_CODE_MAX), $urandom_range(0, DIM_CODE_MAX), $urandom);
        end else if (pick < 80 && rb > 0 && cb > 0) begin
          r1 = $urandom_range(1, rb);
          r2 = $urandom_range(r1, rb);
          c1 = $urandom_range(1, cb);
          c2 = $urandom_range(c1, cb);
          send_word(CMD_QUERY, r1, c1, r2, c2, $urandom);
        end else if (pick < 88) begin
          send_word(CMD_QUERY, $urandom_range(0, DIM_CODE_MAX), $urandom_range(0, DIM_CODE_MAX),
                    $urandom_range(0, DIM_CODE_MAX), $urandom_range(0, DIM_CODE_MAX), $urandom);
        end else if (pick < 95) begin
          r1 = $urandom_range(1) ? 0 : $urandom_range(MAX_DIM + 1, DIM_CODE_MAX);
          c1 = $urandom_range(0, DIM_CODE_MAX);
          if ($urandom_range(1))
            send_word(CMD_LOAD, r1, c1, $urandom_range(0, DIM_CODE_MAX), 0, $urandom);
          else
            send_word(CMD_LOAD, c1, r1, 0, $urandom_range(0, DIM_CODE_MAX), $urandom);
        end else begin
          send_word(CMD_UNUSED, $urandom_range(0, DIM_CODE_MAX), $urandom_range(0, DIM_CODE_MAX),
                    $urandom_range(0, DIM_CODE_MAX), $urandom_range(0, DIM_CODE_MAX), $urandom);
        end
      end
    end

    drain();
    if (sums.errors == 0 && sums.pending_sums.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
src/satq_pkg.sv
src/satq_ram.sv
src/satq_engine.sv
src/summed_area_table_query.sv
src/satq_checker.sv
test/tb_summed_area_table_query.sv
